// File: sv/hlpf_pkg.sv
// Shared types and constants for the histogram last-peak finder.
// No dependencies; hlpf_ctrl and the top level use these by scoped name.
package hlpf_pkg;

  localparam int COUNT_W        = 24;
  localparam int PEAK_W         = 10;
  localparam int PCT_W          = 7;
  localparam int CFG_IDX_W      = 2;
  localparam int DEF_MAX_BINS   = 1024;
  localparam int DEF_COUNT_BITS = 24;
  localparam int PCT_SCALE      = 100;

  localparam logic [PCT_W-1:0] NOISE_RESET  = 7'd10;
  localparam logic [PCT_W-1:0] MARGIN_RESET = 7'd99;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 2'd1;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic               last_bin;
  } bin_item_t;

  typedef struct packed {
    logic [PEAK_W-1:0] peak_bin;
    logic              found;
    logic              truncated;
  } peak_item_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_POST
  } state_t;

endpackage

// File: sv/hlpf_ram.sv
// Bin store: one write port, one read port, registered read data.
// Uses no package items; sized by the parameters handed down.
module hlpf_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/hlpf_ctrl.sv
// Load sequencer and backward scan engine for the last-peak finder.
// Uses hlpf_pkg types; drives the ports of hlpf_ram.
module hlpf_ctrl #(
  parameter int MAX_BINS   = hlpf_pkg::DEF_MAX_BINS,
  parameter int COUNT_BITS = hlpf_pkg::DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          bin_valid,
  output logic                          bin_stall,
  input  hlpf_pkg::bin_item_t           bin_item,
  input  logic [hlpf_pkg::PCT_W-1:0]    noise,
  input  logic [hlpf_pkg::PCT_W-1:0]    margin,
  input  logic                          slot_free,
  output logic                          push,
  output hlpf_pkg::peak_item_t          result,
  output logic                          wr_en,
  output logic [$clog2(MAX_BINS)-1:0]   wr_addr,
  output logic [COUNT_BITS-1:0]         wr_data,
  output logic                          rd_en,
  output logic [$clog2(MAX_BINS)-1:0]   rd_addr,
  input  logic [COUNT_BITS-1:0]         rd_data
);

  localparam int AW  = $clog2(MAX_BINS);
  localparam int BLW = $clog2(MAX_BINS + 1);
  localparam int PW  = COUNT_BITS + hlpf_pkg::PCT_W;

  hlpf_pkg::state_t state, state_next;

  logic [BLW-1:0]        bins_loaded;
  logic [COUNT_BITS-1:0] running_max;
  logic                  overflow;
  logic [PW-1:0]         nmax;
  logic [AW-1:0]         rd_ptr;
  logic                  issuing;
  logic                  few;
  logic                  rv1, rl1;
  logic [AW-1:0]         ri1;
  logic [1:0]            fill;
  logic                  wv, wl;
  logic [AW-1:0]         wi;
  logic [PW-1:0]         win_p100 [4];
  logic [PW-1:0]         win_pm   [4];
  logic [AW-1:0]         res_peak;
  logic                  res_found;

  logic                  accept;
  logic                  has_room;
  logic [COUNT_BITS-1:0] count;
  logic                  hit;
  logic                  scan_end;
  logic [AW-1:0]         cand;

  assign count    = COUNT_BITS'(bin_item.bin_count);
  assign has_room = bins_loaded < BLW'(MAX_BINS);
  assign accept   = bin_valid && !bin_stall;

  assign wr_en   = accept && has_room;
  assign wr_addr = bins_loaded[AW-1:0];
  assign wr_data = count;
  assign rd_addr = rd_ptr;

  // Window slot 3 is the candidate, slots 2..0 the three bins below it.
  assign cand = wi + AW'(3);
  assign hit  = wv && !(win_p100[3] < nmax) &&
                (win_p100[2] < win_pm[3]) &&
                (win_p100[1] < win_pm[3]) &&
                (win_p100[0] < win_pm[3]);
  assign scan_end = few || hit || (wv && wl);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hlpf_pkg::ST_LOAD: begin
        if (accept && bin_item.last_bin) state_next = hlpf_pkg::ST_SCAN;
      end
      hlpf_pkg::ST_SCAN: begin
        if (scan_end) state_next = hlpf_pkg::ST_POST;
      end
      hlpf_pkg::ST_POST: begin
        if (slot_free) state_next = hlpf_pkg::ST_LOAD;
      end
      default: state_next = hlpf_pkg::ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    bin_stall = 1'b1;
    push      = 1'b0;
    rd_en     = 1'b0;
    case (state)
      hlpf_pkg::ST_LOAD: bin_stall = 1'b0;
      hlpf_pkg::ST_SCAN: rd_en = issuing;
      hlpf_pkg::ST_POST: push = slot_free;
      default: bin_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hlpf_pkg::ST_LOAD;
      bins_loaded <= '0;
      running_max <= '0;
      overflow    <= 1'b0;
      issuing     <= 1'b0;
      rv1         <= 1'b0;
      fill        <= '0;
      wv          <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (has_room) begin
          bins_loaded <= bins_loaded + BLW'(1);
          if (bins_loaded != '0 && count > running_max) running_max <= count;
        end else begin
          overflow <= 1'b1;
        end
        if (bin_item.last_bin) issuing <= 1'b1;
      end
      if (state == hlpf_pkg::ST_SCAN) begin
        rv1 <= rd_en;
        if (rd_en && rd_ptr == '0) issuing <= 1'b0;
        if (rv1) begin
          wv <= (fill == 2'd3);
          if (fill != 2'd3) fill <= fill + 2'd1;
        end else begin
          wv <= 1'b0;
        end
        if (scan_end) issuing <= 1'b0;
      end else begin
        rv1  <= 1'b0;
        fill <= '0;
        wv   <= 1'b0;
      end
      if (push) begin
        bins_loaded <= '0;
        running_max <= '0;
        overflow    <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    nmax <= PW'(noise) * PW'(running_max);
    if (accept && bin_item.last_bin) begin
      rd_ptr <= has_room ? bins_loaded[AW-1:0] : AW'(MAX_BINS - 1);
      few    <= has_room && (bins_loaded < BLW'(3));
    end else if (rd_en && rd_ptr != '0) begin
      rd_ptr <= rd_ptr - AW'(1);
    end
    rl1 <= (rd_ptr == '0);
    ri1 <= rd_ptr;
    if (rv1) begin
      for (int i = 3; i > 0; i--) begin
        win_p100[i] <= win_p100[i-1];
        win_pm[i]   <= win_pm[i-1];
      end
      win_p100[0] <= PW'(rd_data) * PW'(hlpf_pkg::PCT_SCALE);
      win_pm[0]   <= PW'(rd_data) * PW'(margin);
      wl <= rl1;
      wi <= ri1;
    end
    if (state == hlpf_pkg::ST_SCAN && scan_end) begin
      res_found <= hit;
      res_peak  <= hit ? cand : '0;
    end
  end

  assign result.peak_bin  = hlpf_pkg::PEAK_W'(res_peak);
  assign result.found     = res_found;
  assign result.truncated = overflow;

endmodule

// File: sv/histogram_last_peak_finder.sv
// Top level of the histogram last-peak finder: config registers, result register.
// Depends on hlpf_pkg, hlpf_ram and hlpf_ctrl.
//
// Usage:
//  - bin channel (bin_valid / bin_stall / bin_item): one bin count per item,
//    underflow bin first, then regular bins 1..N; last_bin marks the final bin.
//    While loading, one item is taken every cycle.
//  - After the last bin the input stalls while the store is scanned from bin N
//    downward, one memory read per cycle through the single read port. The
//    scan ends at the peak, or at bin 3 when no peak is found; fewer than
//    four stored bins give a "not found" result.
//  - peak channel (peak_valid / peak_stall / peak_item): one item per
//    histogram, held in an output register until taken. The next histogram
//    may load while it waits; a second result waits in the engine until the
//    register frees, with the input stalled meanwhile.
//  - cfg_we / cfg_index / cfg_data write noise_percent (index 0) or
//    margin_percent (index 1); other indexes are ignored. Write only when idle.
//  - rst (synchronous) empties the histogram, drops any pending result and
//    restores the percent registers to 10 and 99. The store holds no reset.
module histogram_last_peak_finder #(
  parameter int MAX_BINS   = hlpf_pkg::DEF_MAX_BINS,
  parameter int COUNT_BITS = hlpf_pkg::DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             bin_valid,
  output logic                             bin_stall,
  input  hlpf_pkg::bin_item_t              bin_item,
  output logic                             peak_valid,
  input  logic                             peak_stall,
  output hlpf_pkg::peak_item_t             peak_item,
  input  logic                             cfg_we,
  input  logic [hlpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hlpf_pkg::PCT_W-1:0]       cfg_data
);

  localparam int AW = $clog2(MAX_BINS);

  logic [hlpf_pkg::PCT_W-1:0] noise_percent;
  logic [hlpf_pkg::PCT_W-1:0] margin_percent;

  logic                   slot_free;
  logic                   push;
  hlpf_pkg::peak_item_t   result;
  logic                   wr_en, rd_en;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [COUNT_BITS-1:0]  wr_data, rd_data;

  // Config registers: values are used as written, all 7 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_percent  <= hlpf_pkg::NOISE_RESET;
      margin_percent <= hlpf_pkg::MARGIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hlpf_pkg::REG_NOISE:  noise_percent  <= cfg_data;
        hlpf_pkg::REG_MARGIN: margin_percent <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register: refills in the same cycle it is drained.
  assign slot_free = !peak_valid || !peak_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_valid <= 1'b0;
    end else if (push) begin
      peak_valid <= 1'b1;
    end else if (!peak_stall) begin
      peak_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) peak_item <= result;
  end

  hlpf_ram #(
    .DEPTH (MAX_BINS),
    .WIDTH (COUNT_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hlpf_ctrl #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .bin_valid (bin_valid),
    .bin_stall (bin_stall),
    .bin_item  (bin_item),
    .noise     (noise_percent),
    .margin    (margin_percent),
    .slot_free (slot_free),
    .push      (push),
    .result    (result),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

endmodule
